// File: sv/assert_macros.svh
// Assertion helpers. Both assume a clock clk_i; ASSERT_CK also an active-low reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge, ignored while reset is held.
`define ASSERT_CK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CK(lbl, prop, msg)
`define ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: sv/cpt_pkg.sv
`timescale 1ns / 1ps
package cpt_pkg;
  localparam int unsigned CW = 24;          // coordinate
  localparam int unsigned DW = CW + 1;      // coordinate difference
  localparam int unsigned SW = 52;          // dot product
  localparam int unsigned HW = SW / 2;      // multiplier split
  localparam int unsigned NW = SW + 2;      // edge terms n, m
  localparam int unsigned PW = 2 * SW + 2;  // wide product
  localparam int unsigned RW = PW - 1;      // divider remainder
  localparam int unsigned QW = 16;          // quotient fraction bits
  localparam int unsigned WW = QW + 1;      // weight
  localparam int unsigned BW = CW + WW + 1; // corner times weight
  localparam logic [WW-1:0] ONE_Q16 = WW'(1 << QW);
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));
  localparam int ROUND_HALF = 1 << (QW - 1);

  typedef enum logic [1:0] {MODE_ZERO, MODE_ONE, MODE_DIV, MODE_COMP} mode_e;

  typedef struct packed {
    logic [2:0][CW-1:0] pa;
    logic [2:0][CW-1:0] pb;
    logic [2:0][CW-1:0] pc;
  } coord_t;

  typedef struct packed {
    logic signed [NW-1:0] ne;  // -e
    logic signed [NW-1:0] nd;  // -d
    logic signed [NW-1:0] na;
    logic signed [NW-1:0] nc;
    logic signed [NW-1:0] nn;  // c + e - b - d
    logic signed [NW-1:0] nm;  // a + c - 2b
  } small_t;

  typedef struct packed {
    mode_e ac;
    mode_e ab;
    mode_e bc;
  } emode_t;

  typedef struct packed {
    mode_e       mode;
    logic [RW-1:0] num;
    logic [RW-1:0] den;
  } lane_t;
endpackage

// File: sv/cpt_mul52.sv
`timescale 1ns / 1ps
module cpt_mul52 import cpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [SW-1:0] x_i,
  input  logic signed [SW-1:0] y_i,
  output logic signed [PW-1:0] p_o
);
  logic [SW-1:0]   ux, uy;
  logic [2*HW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic            neg_q;
  logic [2*SW-1:0] mag;
  logic signed [PW-1:0] p_q;

  assign ux = x_i[SW-1] ? SW'(0) - SW'(x_i) : SW'(x_i);
  assign uy = y_i[SW-1] ? SW'(0) - SW'(y_i) : SW'(y_i);

  // First cycle forms four half-width partial products of the magnitudes.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= ux[HW-1:0] * uy[HW-1:0];
      p01_q <= ux[HW-1:0] * uy[SW-1:HW];
      p10_q <= ux[SW-1:HW] * uy[HW-1:0];
      p11_q <= ux[SW-1:HW] * uy[SW-1:HW];
      neg_q <= x_i[SW-1] ^ y_i[SW-1];
    end
  end

  assign mag = (2*SW)'(p00_q) + ((2*SW)'(p01_q) << HW) + ((2*SW)'(p10_q) << HW)
             + ((2*SW)'(p11_q) << (2*HW));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q ? PW'(0) - $signed(PW'(mag)) : $signed(PW'(mag));
    end
  end

  assign p_o = p_q;
endmodule

// File: sv/cpt_div_step.sv
`timescale 1ns / 1ps
module cpt_div_step import cpt_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] den_o,
  output logic [QW-1:0] quo_o
);
  logic [RW:0]   sh, diff;
  logic          ge;
  logic [RW-1:0] rem_q, den_q;
  logic [QW-1:0] quo_q;

  // One restoring step; the remainder always stays below the divisor.
  assign sh   = {rem_i, 1'b0};
  assign diff = sh - {1'b0, den_i};
  assign ge   = !diff[RW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? diff[RW-1:0] : sh[RW-1:0];
      den_q <= den_i;
      quo_q <= {quo_i[QW-2:0], ge};
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;
endmodule

// File: sv/closest_point_on_triangle.sv
`timescale 1ns / 1ps
// Channel  | Dir | Payload (low bits first)
// s_axis   | in  | query x,y,z, corner a x,y,z, corner b x,y,z, corner c x,y,z (24 b each)
// m_axis   | out | near x,y,z (24 b), weight a,b,c (17 b), 5 zero bits
//
// One transfer is accepted per cycle while the pipeline is not held.
// The depth comes from the split 52x52 multipliers and the 16-step restoring divider.
// The whole pipeline advances together; it holds while a result waits to be taken.
// Reset clears only the stage valid bits.
`include "assert_macros.svh"
module closest_point_on_triangle import cpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // query_x,y,z, corner_a_x,y,z, corner_b_x,y,z, corner_c_x,y,z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // near_x, near_y, near_z, weight_a, weight_b, weight_c, zero pad
  output logic [127:0] m_axis_tdata
);
  localparam int unsigned DIV0 = 7;
  localparam int unsigned CLP  = DIV0 + QW;
  localparam int unsigned NST  = CLP + 3;

  logic            adv;
  logic [NST-1:0]  vld_q;
  logic [2:0][CW-1:0] qry;
  coord_t          in_c;
  coord_t          crd_q [CLP+1];

  logic signed [DW-1:0]   e0_q [3], e1_q [3], t_q [3];
  logic signed [2*DW-1:0] paa_q [3], pbb_q [3], pcc_q [3], pdd_q [3], pee_q [3];
  logic signed [SW-1:0]   a_q, b_q, c_q, d_q, e_q;
  logic signed [PW-1:0]   m_be, m_cd, m_bd, m_ae, m_ac, m_bb;
  logic signed [PW-1:0]   sn_q, tn_q, det_q;
  logic signed [PW:0]     snt;
  small_t          sm_q [3];
  emode_t          em5_q, em6_q;
  lane_t           lb_d, lc_d, lb_q, lc_q;
  mode_e           mdb_q [QW], mdc_q [QW];
  logic [RW-1:0]   remb [QW+1], denb [QW+1], remc [QW+1], denc [QW+1];
  logic [QW-1:0]   quob [QW+1], quoc [QW+1];
  logic [WW-1:0]   wb_d, wc_d, wa_d, wa_q, wb_q, wc_q, wa2_q, wb2_q, wc2_q;
  logic signed [WW+1:0] wa_s;
  logic signed [BW-1:0] ma_q [3], mb_q [3], mc_q [3];
  logic signed [BW+1:0] tsum [3], vsh [3];
  logic [2:0][CW-1:0] near_d, near_q;
  logic [WW-1:0]   wa_o_q, wb_o_q, wc_o_q;

  function automatic mode_e small_mode(input logic signed [NW-1:0] num,
                                       input logic signed [NW-1:0] den);
    mode_e md;
    if (den == '0 || num <= 0) md = MODE_ZERO;
    else if (num >= den) md = MODE_ONE;
    else md = MODE_DIV;
    return md;
  endfunction

  assign adv = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qry[k]     = s_axis_tdata[k*CW +: CW];
      in_c.pa[k] = s_axis_tdata[(3+k)*CW +: CW];
      in_c.pb[k] = s_axis_tdata[(6+k)*CW +: CW];
      in_c.pc[k] = s_axis_tdata[(9+k)*CW +: CW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      crd_q[0] <= in_c;
      for (int i = 1; i <= CLP; i++) crd_q[i] <= crd_q[i-1];
    end
  end

  // Edges, offsets, products and dot products.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e0_q[k]  <= DW'($signed(in_c.pb[k])) - DW'($signed(in_c.pa[k]));
        e1_q[k]  <= DW'($signed(in_c.pc[k])) - DW'($signed(in_c.pa[k]));
        t_q[k]   <= DW'($signed(in_c.pa[k])) - DW'($signed(qry[k]));
        paa_q[k] <= e0_q[k] * e0_q[k];
        pbb_q[k] <= e0_q[k] * e1_q[k];
        pcc_q[k] <= e1_q[k] * e1_q[k];
        pdd_q[k] <= e0_q[k] * t_q[k];
        pee_q[k] <= e1_q[k] * t_q[k];
      end
      a_q <= SW'(paa_q[0]) + SW'(paa_q[1]) + SW'(paa_q[2]);
      b_q <= SW'(pbb_q[0]) + SW'(pbb_q[1]) + SW'(pbb_q[2]);
      c_q <= SW'(pcc_q[0]) + SW'(pcc_q[1]) + SW'(pcc_q[2]);
      d_q <= SW'(pdd_q[0]) + SW'(pdd_q[1]) + SW'(pdd_q[2]);
      e_q <= SW'(pee_q[0]) + SW'(pee_q[1]) + SW'(pee_q[2]);
    end
  end

  cpt_mul52 u_mul_be (.clk_i, .en_i(adv), .x_i(b_q), .y_i(e_q), .p_o(m_be));
  cpt_mul52 u_mul_cd (.clk_i, .en_i(adv), .x_i(c_q), .y_i(d_q), .p_o(m_cd));
  cpt_mul52 u_mul_bd (.clk_i, .en_i(adv), .x_i(b_q), .y_i(d_q), .p_o(m_bd));
  cpt_mul52 u_mul_ae (.clk_i, .en_i(adv), .x_i(a_q), .y_i(e_q), .p_o(m_ae));
  cpt_mul52 u_mul_ac (.clk_i, .en_i(adv), .x_i(a_q), .y_i(c_q), .p_o(m_ac));
  cpt_mul52 u_mul_bb (.clk_i, .en_i(adv), .x_i(b_q), .y_i(b_q), .p_o(m_bb));

  // Edge terms travel beside the multipliers; their clamp modes are settled early.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_q[0].ne <= NW'(0) - NW'(e_q);
      sm_q[0].nd <= NW'(0) - NW'(d_q);
      sm_q[0].na <= NW'(a_q);
      sm_q[0].nc <= NW'(c_q);
      sm_q[0].nn <= NW'(c_q) + NW'(e_q) - NW'(b_q) - NW'(d_q);
      sm_q[0].nm <= NW'(a_q) + NW'(c_q) - (NW'(b_q) <<< 1);
      sm_q[1] <= sm_q[0];
      sm_q[2] <= sm_q[1];
      em5_q.ac <= small_mode(sm_q[0].ne, sm_q[0].nc);
      em5_q.ab <= small_mode(sm_q[0].nd, sm_q[0].na);
      em5_q.bc <= small_mode(sm_q[0].nn, sm_q[0].nm);
      em6_q <= em5_q;
      sn_q  <= m_be - m_cd;
      tn_q  <= m_bd - m_ae;
      det_q <= m_ac - m_bb;
    end
  end

  // Region choice sets up both divider lanes.
  assign snt = (PW+1)'(sn_q) + (PW+1)'(tn_q);

  always_comb begin
    lb_d = '{mode: MODE_ZERO, num: '0, den: '0};
    lc_d = '{mode: MODE_ZERO, num: '0, den: '0};
    if (sn_q[PW-1] || sn_q == '0) begin
      lc_d = '{mode: em6_q.ac, num: RW'(sm_q[2].ne), den: RW'(sm_q[2].nc)};
    end else if (tn_q[PW-1] || tn_q == '0) begin
      lb_d = '{mode: em6_q.ab, num: RW'(sm_q[2].nd), den: RW'(sm_q[2].na)};
    end else if ((PW+1)'(det_q) < snt) begin
      lb_d = '{mode: em6_q.bc, num: RW'(sm_q[2].nn), den: RW'(sm_q[2].nm)};
      if (sm_q[2].nm != '0) lc_d.mode = MODE_COMP;
    end else if (det_q != '0) begin
      lb_d = '{mode: MODE_DIV, num: RW'(sn_q), den: RW'(det_q)};
      lc_d = '{mode: MODE_DIV, num: RW'(tn_q), den: RW'(det_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lb_q <= lb_d;
      lc_q <= lc_d;
      mdb_q[0] <= lb_q.mode;
      mdc_q[0] <= lc_q.mode;
      for (int i = 1; i < QW; i++) begin
        mdb_q[i] <= mdb_q[i-1];
        mdc_q[i] <= mdc_q[i-1];
      end
    end
  end

  assign remb[0] = (lb_q.mode == MODE_DIV) ? lb_q.num : '0;
  assign denb[0] = (lb_q.mode == MODE_DIV) ? lb_q.den : RW'(1);
  assign remc[0] = (lc_q.mode == MODE_DIV) ? lc_q.num : '0;
  assign denc[0] = (lc_q.mode == MODE_DIV) ? lc_q.den : RW'(1);
  assign quob[0] = '0;
  assign quoc[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    cpt_div_step u_step_b (
      .clk_i, .en_i(adv), .rem_i(remb[g]), .den_i(denb[g]), .quo_i(quob[g]),
      .rem_o(remb[g+1]), .den_o(denb[g+1]), .quo_o(quob[g+1])
    );
    cpt_div_step u_step_c (
      .clk_i, .en_i(adv), .rem_i(remc[g]), .den_i(denc[g]), .quo_i(quoc[g]),
      .rem_o(remc[g+1]), .den_o(denc[g+1]), .quo_o(quoc[g+1])
    );
  end

  // Clamp and complete the weights.
  always_comb begin
    case (mdb_q[QW-1])
      MODE_ONE: wb_d = ONE_Q16;
      MODE_DIV: wb_d = WW'(quob[QW]);
      default:  wb_d = '0;
    endcase
    case (mdc_q[QW-1])
      MODE_ONE:  wc_d = ONE_Q16;
      MODE_DIV:  wc_d = WW'(quoc[QW]);
      MODE_COMP: wc_d = ONE_Q16 - wb_d;
      default:   wc_d = '0;
    endcase
    wa_s = (WW+2)'(ONE_Q16) - (WW+2)'(wb_d) - (WW+2)'(wc_d);
    if (wa_s < 0) wa_d = '0;
    else if (wa_s > $signed((WW+2)'(ONE_Q16))) wa_d = ONE_Q16;
    else wa_d = WW'(wa_s);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wa_q <= wa_d;
      wb_q <= wb_d;
      wc_q <= wc_d;
      for (int k = 0; k < 3; k++) begin
        ma_q[k] <= $signed(crd_q[CLP].pa[k]) * $signed({1'b0, wa_q});
        mb_q[k] <= $signed(crd_q[CLP].pb[k]) * $signed({1'b0, wb_q});
        mc_q[k] <= $signed(crd_q[CLP].pc[k]) * $signed({1'b0, wc_q});
      end
      wa2_q <= wa_q;
      wb2_q <= wb_q;
      wc2_q <= wc_q;
    end
  end

  // Round to eight fraction bits, floor on the shift, then saturate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsum[k] = (BW+2)'(ma_q[k]) + (BW+2)'(mb_q[k]) + (BW+2)'(mc_q[k])
              + (BW+2)'(ROUND_HALF);
      vsh[k]  = tsum[k] >>> QW;
      if (vsh[k] > $signed((BW+2)'(CMAX))) near_d[k] = CW'(CMAX);
      else if (vsh[k] < $signed((BW+2)'(CMIN))) near_d[k] = CW'(CMIN);
      else near_d[k] = CW'(vsh[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      near_q <= near_d;
      wa_o_q <= wa2_q;
      wb_o_q <= wb2_q;
      wc_o_q <= wc2_q;
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {5'b0, wc_o_q, wb_o_q, wa_o_q, near_q[2], near_q[1], near_q[0]};

  `ASSERT_NR(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "output valid during reset")
  `ASSERT_CK(a_enter, s_axis_tvalid && s_axis_tready |=> vld_q[0], "accepted item lost")
  `ASSERT_CK(a_lane_b, vld_q[DIV0-1] && lb_q.mode == MODE_DIV |-> lb_q.num < lb_q.den, "lane b quotient not below one")
  `ASSERT_CK(a_lane_c, vld_q[DIV0-1] && lc_q.mode == MODE_DIV |-> lc_q.num < lc_q.den, "lane c quotient not below one")
  `ASSERT_CK(a_wsum, m_axis_tvalid |-> wa_o_q == '0 || (WW+2)'(wa_o_q) + (WW+2)'(wb_o_q) + (WW+2)'(wc_o_q) == (WW+2)'(ONE_Q16), "weights do not sum to one")
endmodule

// File: tb/closest_point_on_triangle_test.sv
`timescale 1ns / 1ps
module closest_point_on_triangle_test;
  import cpt_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic [11:0][23:0] query_set_t;

  typedef struct {
    query_set_t   f;
    bit           fixed;
    logic [127:0] res;
  } stim_t;

  localparam int N_RANDOM = 1400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int PAUSE_AT = 600;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  stim_t        stim_q[$];
  logic [127:0] expected_q[$];
  int           errors = 0;
  int           sent = 0;
  int           received = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;
  bit           held_long = 1'b0;

  always #6 clk_i = ~clk_i;

  closest_point_on_triangle DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic logic [127:0] pack_result(logic [23:0] nx, ny, nz,
                                               logic [16:0] wa, wb, wc);
    logic [127:0] r;
    r = '0;
    r[23:0] = nx;
    r[47:24] = ny;
    r[71:48] = nz;
    r[88:72] = wa;
    r[105:89] = wb;
    r[122:106] = wc;
    return r;
  endfunction

  // Sixteen fraction bits of num/den by restoring division, 0 <= num < den.
  function automatic longint frac_q16(wide_t num, wide_t den);
    wide_t  r;
    longint q;
    r = num;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r <<< 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint weight_div(longint n, longint d);
    if (n <= 0) return 0;
    if (n >= d) return 65536;
    return frac_q16(wide_t'(n), wide_t'(d));
  endfunction

  function automatic logic [23:0] blend_coord(longint pa, pb, pc, wa, wb, wc);
    longint t;
    longint v;
    t = pa * wa + pb * wb + pc * wc + 32768;
    v = t >>> 16;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic logic [127:0] nearest_point(query_set_t f);
    longint q[3], pa[3], pb[3], pc[3];
    longint a, b, c, d, e, e0, e1, t, wa, wb, wc, m, n;
    wide_t  sn, tn, det;
    logic [23:0] nr[3];
    a = 0; b = 0; c = 0; d = 0; e = 0; wb = 0; wc = 0;
    for (int k = 0; k < 3; k++) begin
      q[k] = longint'($signed(f[k]));
      pa[k] = longint'($signed(f[3 + k]));
      pb[k] = longint'($signed(f[6 + k]));
      pc[k] = longint'($signed(f[9 + k]));
      e0 = pb[k] - pa[k];
      e1 = pc[k] - pa[k];
      t = pa[k] - q[k];
      a += e0 * e0;
      b += e0 * e1;
      c += e1 * e1;
      d += e0 * t;
      e += e1 * t;
    end
    sn = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
    tn = wide_t'(b) * wide_t'(d) - wide_t'(a) * wide_t'(e);
    det = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
    if (sn <= 0) begin
      if (c != 0) wc = weight_div(-e, c);
    end else if (tn <= 0) begin
      if (a != 0) wb = weight_div(-d, a);
    end else if (sn + tn > det) begin
      m = a + c - b - b;
      n = c + e - b - d;
      if (m != 0) begin
        wb = weight_div(n, m);
        wc = 65536 - wb;
      end
    end else if (det != 0) begin
      wb = frac_q16(sn, det);
      wc = frac_q16(tn, det);
    end
    wa = 65536 - wb - wc;
    if (wa < 0) wa = 0;
    if (wa > 65536) wa = 65536;
    for (int k = 0; k < 3; k++) nr[k] = blend_coord(pa[k], pb[k], pc[k], wa, wb, wc);
    return pack_result(nr[0], nr[1], nr[2], wa[16:0], wb[16:0], wc[16:0]);
  endfunction

  function automatic query_set_t make_set(int qx, qy, qz, ax, ay, az,
                                          bx, by, bz, cx, cy, cz);
    query_set_t s;
    s[0] = qx[23:0]; s[1] = qy[23:0]; s[2] = qz[23:0];
    s[3] = ax[23:0]; s[4] = ay[23:0]; s[5] = az[23:0];
    s[6] = bx[23:0]; s[7] = by[23:0]; s[8] = bz[23:0];
    s[9] = cx[23:0]; s[10] = cy[23:0]; s[11] = cz[23:0];
    return s;
  endfunction

  task automatic add_row(query_set_t f, bit fixed, logic [127:0] res);
    stim_t s;
    s.f = f;
    s.fixed = fixed;
    s.res = res;
    stim_q.push_back(s);
  endtask

  // Triangles with coincident corners have a zero divisor, so the answer is corner A.
  task automatic add_corner_a_row(query_set_t f);
    add_row(f, 1'b1, pack_result(f[3], f[4], f[5], ONE_Q16, '0, '0));
  endtask

  function automatic int rand_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic query_set_t random_set();
    query_set_t s;
    int base[3];
    int span;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      for (int k = 0; k < 12; k++) s[k] = $urandom();
    end else if (kind == 2) begin
      // Degenerate: collinear or coincident corners.
      for (int k = 0; k < 3; k++) begin
        base[k] = rand_coord(100000);
        s[k] = rand_coord(200000);
        s[3 + k] = base[k];
        s[6 + k] = base[k] + rand_coord(3) * 16;
        s[9 + k] = base[k] + (s[6 + k] - base[k]) * $urandom_range(0, 2);
      end
    end else begin
      span = (kind < 6) ? 2000 : 300000;
      for (int k = 0; k < 3; k++) base[k] = rand_coord(4000000);
      for (int k = 0; k < 3; k++) begin
        s[3 + k] = base[k] + rand_coord(span);
        s[6 + k] = base[k] + rand_coord(span);
        s[9 + k] = base[k] + rand_coord(span);
        s[k] = base[k] + rand_coord(span * 2);
      end
    end
    return s;
  endfunction

  task automatic check_result(logic [127:0] exp, logic [127:0] act);
    if (exp[23:0] !== act[23:0]) begin
      $error("near_x expected %0d actual %0d", $signed(exp[23:0]), $signed(act[23:0]));
      errors++;
    end
    if (exp[47:24] !== act[47:24]) begin
      $error("near_y expected %0d actual %0d", $signed(exp[47:24]), $signed(act[47:24]));
      errors++;
    end
    if (exp[71:48] !== act[71:48]) begin
      $error("near_z expected %0d actual %0d", $signed(exp[71:48]), $signed(act[71:48]));
      errors++;
    end
    if (exp[88:72] !== act[88:72]) begin
      $error("weight_a expected %0d actual %0d", exp[88:72], act[88:72]);
      errors++;
    end
    if (exp[105:89] !== act[105:89]) begin
      $error("weight_b expected %0d actual %0d", exp[105:89], act[105:89]);
      errors++;
    end
    if (exp[122:106] !== act[122:106]) begin
      $error("weight_c expected %0d actual %0d", exp[122:106], act[122:106]);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      received <= received + 1;
      if (expected_q.size() == 0) begin
        $error("result with no pending query, data %h", m_axis_tdata);
        errors++;
      end else begin
        check_result(expected_q.pop_front(), m_axis_tdata);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off to back the pipeline up.
  initial begin
    wait (rst_ni);
    forever begin
      if (!held_long && sent >= 400) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int a;
    query_set_t unit;
    stim_t s;

    a = 256;
    // Reference triangle A=0, B=(1,0,0), C=(0,1,0) in Q15.8.
    add_corner_a_row(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_corner_a_row(make_set(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                              CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    add_corner_a_row(make_set(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                              CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    add_corner_a_row(make_set(5, -7, 9, 100, 200, 300, 100, 200, 300, 100, 200, 300));
    unit = make_set(64, 64, 0, 0, 0, 0, a, 0, 0, 0, a, 0);
    add_row(unit, 1'b1, pack_result(24'sd64, 24'sd64, 24'sd0, 17'd32768, 17'd16384, 17'd16384));
    add_row(make_set(1000, -100, 50, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b1,
            pack_result(a, 0, 0, 17'd0, ONE_Q16, 17'd0));
    add_row(make_set(-100, 1000, 0, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b1,
            pack_result(0, a, 0, 17'd0, 17'd0, ONE_Q16));
    add_row(make_set(-100, -100, 7, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b1,
            pack_result(0, 0, 0, ONE_Q16, 17'd0, 17'd0));
    add_row(make_set(500, 500, 0, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b0, '0);
    add_row(make_set(-50, 100, 0, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b0, '0);
    add_row(make_set(100, -50, 0, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b0, '0);
    add_row(make_set(300, -20, 0, 0, 0, 0, a, 0, 0, 0, a, 0), 1'b0, '0);
    add_row(make_set(10, 20, 30, 0, 0, 0, a, 0, 0, 2 * a, 0, 0), 1'b0, '0);
    add_row(make_set(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN,
                     CMIN, CMIN, CMAX), 1'b0, '0);
    add_row(make_set(CMIN, CMAX, 0, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX,
                     CMAX, CMAX, CMIN), 1'b0, '0);
    add_row(make_set(CMAX, CMAX, CMAX, CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN), 1'b0, '0);
    add_row(make_set(-1, -1, -1, -1, -1, -1, 0, -1, -1, -1, 0, -1), 1'b0, '0);
    for (int i = 0; i < N_RANDOM; i++) add_row(random_set(), 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (stim_q.size() > 0) begin
      s = stim_q.pop_front();
      if (sent == PAUSE_AT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (expected_q.size() > 0) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= s.f;
      do @(posedge clk_i); while (!s_axis_tready);
      expected_q.push_back(s.fixed ? s.res : nearest_point(s.f));
      sent++;
      if (sent > N_RANDOM - 150) quiet = 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d queries: corner extremes, degenerate triangles, all four regions,",
             sent);
    $display("with random stalls on both sides, one long output hold-off and one drain pause");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: closest_point_on_triangle.f
+incdir+sv
sv/cpt_pkg.sv
sv/cpt_mul52.sv
sv/cpt_div_step.sv
sv/closest_point_on_triangle.sv
tb/closest_point_on_triangle_test.sv
